// ===== design/lru_pkg.sv =====
`timescale 1ns / 1ps

package lru_pkg;

    // frame store geometry
    localparam int FRAMES    = 8;
    localparam int PAGE_BITS = 16;

    localparam int FIDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int AGE_W   = FIDX_W;
    localparam int CNT_W   = $clog2(FRAMES + 1);
    localparam int ENTRY_W = PAGE_BITS + AGE_W;

    // configuration register
    localparam int          FC_W            = 4;
    localparam logic [FC_W-1:0] FC_RESET    = 4'd8;
    localparam int          PADDR_W         = 3;
    localparam logic        REG_FRAME_COUNT = 1'b0;

    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic                 last;
    } in_word_t;

    typedef struct packed {
        logic                 hit;
        logic [2:0]           frame_index;
        logic                 evicted_valid;
        logic [PAGE_BITS-1:0] evicted_page;
        logic [31:0]          hit_total;
        logic [31:0]          fault_total;
        logic                 final_res;
    } out_word_t;

    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic [AGE_W-1:0]     age;
    } frame_entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_UPD,
        S_DONE
    } eng_state_t;

endpackage

// ===== design/lru_frame_ram.sv =====
`timescale 1ns / 1ps

module lru_frame_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/lru_engine.sv =====
`timescale 1ns / 1ps

module lru_engine
    import lru_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  in_word_t         req,
    input  logic [CNT_W-1:0] n_act,
    output logic             res_valid,
    input  logic             res_stall,
    output out_word_t        res
);

    eng_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [FRAMES-1:0]    valid_reg, valid_next;
    logic [31:0]          hits_reg, hits_next;
    logic [31:0]          faults_reg, faults_next;
    logic                 found_reg, found_next;
    logic                 empty_reg, empty_next;
    logic                 ev_reg, ev_next;

    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic                 last_reg, last_next;
    logic [FIDX_W-1:0]    hit_slot_reg, hit_slot_next;
    logic [AGE_W-1:0]     hit_age_reg, hit_age_next;
    logic [FIDX_W-1:0]    empty_slot_reg, empty_slot_next;
    logic [FIDX_W-1:0]    vict_slot_reg, vict_slot_next;
    logic [AGE_W-1:0]     vict_age_reg, vict_age_next;
    logic [PAGE_BITS-1:0] vict_page_reg, vict_page_next;
    logic [FIDX_W-1:0]    slot_reg, slot_next;
    logic [CNT_W-1:0]     limit_reg, limit_next;

    logic                 re;
    logic                 we;
    logic [FIDX_W-1:0]    raddr;
    logic [FIDX_W-1:0]    pidx;
    logic [ENTRY_W-1:0]   rdata;
    logic [ENTRY_W-1:0]   wdata;
    frame_entry_t         rd_ent;
    frame_entry_t         wr_ent;

    lru_frame_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FRAMES),
        .AW    (FIDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (pidx),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_ent    = frame_entry_t'(rdata);
    assign wdata     = ENTRY_W'(wr_ent);
    assign raddr     = cnt_reg[FIDX_W-1:0];
    assign pidx      = FIDX_W'(cnt_reg - 1'b1);
    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        valid_next      = valid_reg;
        hits_next       = hits_reg;
        faults_next     = faults_reg;
        found_next      = found_reg;
        empty_next      = empty_reg;
        ev_next         = ev_reg;
        page_next       = page_reg;
        last_next       = last_reg;
        hit_slot_next   = hit_slot_reg;
        hit_age_next    = hit_age_reg;
        empty_slot_next = empty_slot_reg;
        vict_slot_next  = vict_slot_reg;
        vict_age_next   = vict_age_reg;
        vict_page_next  = vict_page_reg;
        slot_next       = slot_reg;
        limit_next      = limit_reg;
        re              = 1'b0;
        we              = 1'b0;
        wr_ent          = rd_ent;
        res_valid       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    page_next  = req.page;
                    last_next  = req.last;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    empty_next = 1'b0;
                    state_next = S_SCAN;
                end
            end

            // one frame read per cycle, its data checked in the cycle after the read
            S_SCAN:
            begin
                re = (cnt_reg < n_act);
                if (cnt_reg != '0)
                begin
                    if (valid_reg[pidx] && rd_ent.page == page_reg && !found_reg)
                    begin
                        found_next    = 1'b1;
                        hit_slot_next = pidx;
                        hit_age_next  = rd_ent.age;
                    end
                    if (!valid_reg[pidx] && !empty_reg)
                    begin
                        empty_next      = 1'b1;
                        empty_slot_next = pidx;
                    end
                    if (pidx == '0 || rd_ent.age > vict_age_reg)
                    begin
                        vict_slot_next = pidx;
                        vict_age_next  = rd_ent.age;
                        vict_page_next = rd_ent.page;
                    end
                end
                if (cnt_reg == n_act)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_DECIDE:
            begin
                ev_next = 1'b0;
                if (found_reg)
                begin
                    slot_next  = hit_slot_reg;
                    limit_next = CNT_W'(hit_age_reg);
                    if (hits_reg != '1)
                    begin
                        hits_next = hits_reg + 1'b1;
                    end
                end
                else
                begin
                    if (empty_reg)
                    begin
                        slot_next  = empty_slot_reg;
                        limit_next = CNT_W'(FRAMES);
                    end
                    else
                    begin
                        slot_next  = vict_slot_reg;
                        limit_next = CNT_W'(vict_age_reg);
                        ev_next    = 1'b1;
                    end
                    if (faults_reg != '1)
                    begin
                        faults_next = faults_reg + 1'b1;
                    end
                end
                valid_next[slot_next] = 1'b1;
                cnt_next   = '0;
                state_next = S_UPD;
            end

            // read-modify-write of ages, each write follows in the cycle after its read
            S_UPD:
            begin
                re = (cnt_reg < n_act);
                if (cnt_reg != '0)
                begin
                    we = 1'b1;
                    if (pidx == slot_reg)
                    begin
                        wr_ent.page = page_reg;
                        wr_ent.age  = '0;
                    end
                    else if (valid_reg[pidx] && CNT_W'(rd_ent.age) < limit_reg &&
                             rd_ent.age != AGE_W'(FRAMES - 1))
                    begin
                        wr_ent.age = rd_ent.age + 1'b1;
                    end
                end
                if (cnt_reg == n_act)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (!res_stall)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.hit           = found_reg;
        res.frame_index   = 3'(slot_reg);
        res.evicted_valid = ev_reg;
        res.evicted_page  = ev_reg ? vict_page_reg : '0;
        res.hit_total     = hits_reg;
        res.fault_total   = faults_reg;
        res.final_res     = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            valid_reg  <= '0;
            hits_reg   <= '0;
            faults_reg <= '0;
            found_reg  <= 1'b0;
            empty_reg  <= 1'b0;
            ev_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            valid_reg  <= valid_next;
            hits_reg   <= hits_next;
            faults_reg <= faults_next;
            found_reg  <= found_next;
            empty_reg  <= empty_next;
            ev_reg     <= ev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg       <= page_next;
        last_reg       <= last_next;
        hit_slot_reg   <= hit_slot_next;
        hit_age_reg    <= hit_age_next;
        empty_slot_reg <= empty_slot_next;
        vict_slot_reg  <= vict_slot_next;
        vict_age_reg   <= vict_age_next;
        vict_page_reg  <= vict_page_next;
        slot_reg       <= slot_next;
        limit_reg      <= limit_next;
    end

    // a hit never evicts
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.hit && res.evicted_valid))
        else $error("hit reported with eviction");

    // the chosen frame is resident once the decision is made
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DECIDE |=> valid_reg[slot_reg])
        else $error("chosen frame not marked resident");

    // totals never go backwards
    assert property (@(posedge clk) disable iff (!rst_n)
        hits_reg >= $past(hits_reg) && faults_reg >= $past(faults_reg))
        else $error("hit or fault total decreased");

    // exactly one of the totals moves per reference
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DECIDE && hits_reg != '1 && faults_reg != '1 |=>
        (hits_reg != $past(hits_reg)) != (faults_reg != $past(faults_reg)))
        else $error("totals not updated once per reference");

endmodule

// ===== design/lru_page_replacement.sv =====
`timescale 1ns / 1ps

// lru page replacement over a fully associative set of frames
//
// req channel (req_valid / req_stall / req): one page reference per word,
// taken at a clock edge with req_valid high and req_stall low
// rsp channel (rsp_valid / rsp_stall / rsp): one result word per reference,
// held steady while rsp_stall is high
// apb port: register 0 (byte address 0) is frame_count, 4 bits, reset 8;
// a count of zero acts as one, a count above the frame store acts as full
//
// each reference walks the frame memory twice, one frame per cycle: a
// search pass (match, first empty frame, oldest frame) and an age
// update pass that writes back behind the read; the next word is taken
// once the result has moved to the output register
// a stalled result waits in the output register; one further reference can
// complete behind it and then holds req_stall high until the register frees
// reset empties all frames and clears the totals; frame pages and ages live
// in memory with no reset, per-frame valid bits sit in flip-flops

module lru_page_replacement
    import lru_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  in_word_t           req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output out_word_t          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [FC_W-1:0]  fc_reg;
    logic [CNT_W-1:0] n_act;
    logic             res_valid;
    logic             res_stall;
    out_word_t        res;
    logic             rsp_valid_reg;
    out_word_t        rsp_reg;

    // register file: only frame_count, bit 2 of the byte address selects it
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FRAME_COUNT) ? 32'(fc_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg <= FC_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_FRAME_COUNT)
        begin
            fc_reg <= pwdata[FC_W-1:0];
        end
    end

    // frames in use, clamped to the range 1 .. FRAMES
    always_comb
    begin
        if (fc_reg == '0)
        begin
            n_act = CNT_W'(1);
        end
        else if (32'(fc_reg) > 32'(FRAMES))
        begin
            n_act = CNT_W'(FRAMES);
        end
        else
        begin
            n_act = CNT_W'(fc_reg);
        end
    end

    lru_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .n_act     (n_act),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // output register, frees the engine as soon as a result is parked
    assign res_stall = rsp_valid_reg && rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid && !res_stall)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && !res_stall)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

// self-checking bench for the lru page replacement block
// a directed table runs first, then randomized phases, each at its own frame count
// every accepted word is predicted by a local lru model and checked in order

module tb_top
    import lru_pkg::*;
();

    // register map: frame_count is register 0, byte address 0
    localparam logic [PADDR_W-1:0] ADDR_FRAME_COUNT = PADDR_W'(4 * REG_FRAME_COUNT);
    // register index 1 does not exist, writes there are dropped
    localparam logic [PADDR_W-1:0] ADDR_SPARE       = PADDR_W'(4);

    localparam int MAX_GAP      = 17;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;
    localparam int N_PHASES     = 10;
    localparam int PHASE_WORDS  = 105;
    localparam int N_DIR        = 22;

    localparam out_word_t NO_RESULT = '0;

    // directed row: {set count first, count, page, last, typed result, result}
    typedef struct packed {
        logic            set_count;
        logic [FC_W-1:0] count;
        logic [15:0]     page;
        logic            last;
        logic            typed;
        out_word_t       result;
    } dir_row_t;

    // typed results are {hit, frame, evicted, evicted page, hits, faults, final}
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        // empty store after reset: fault into frame 0, then frame 1
        {1'b0, 4'd0, 16'h0000, 1'b0, 1'b1,
            {1'b0, 3'd0, 1'b0, 16'h0000, 32'd0, 32'd1, 1'b0}},
        {1'b0, 4'd0, 16'hffff, 1'b1, 1'b1,
            {1'b0, 3'd1, 1'b0, 16'h0000, 32'd0, 32'd2, 1'b1}},
        // first hit
        {1'b0, 4'd0, 16'h0000, 1'b0, 1'b1,
            {1'b1, 3'd0, 1'b0, 16'h0000, 32'd1, 32'd2, 1'b0}},
        // fill the rest of the store
        {1'b0, 4'd0, 16'h0002, 1'b0, 1'b0, NO_RESULT},
        {1'b0, 4'd0, 16'h0003, 1'b0, 1'b0, NO_RESULT},
        {1'b0, 4'd0, 16'h0004, 1'b0, 1'b0, NO_RESULT},
        {1'b0, 4'd0, 16'h0005, 1'b0, 1'b0, NO_RESULT},
        {1'b0, 4'd0, 16'h0006, 1'b0, 1'b0, NO_RESULT},
        {1'b0, 4'd0, 16'h0007, 1'b0, 1'b0, NO_RESULT},
        // store full: evictions of the least recent frame
        {1'b0, 4'd0, 16'h0008, 1'b0, 1'b0, NO_RESULT},
        {1'b0, 4'd0, 16'hffff, 1'b0, 1'b0, NO_RESULT},
        // count zero acts as one frame, page 3 now also sits outside the count
        {1'b1, 4'd0, 16'h0003, 1'b0, 1'b0, NO_RESULT},
        {1'b0, 4'd0, 16'h0003, 1'b0, 1'b0, NO_RESULT},
        // count above the store saturates, duplicate page hits the lowest frame
        {1'b1, 4'd15, 16'h0003, 1'b0, 1'b0, NO_RESULT},
        {1'b0, 4'd0, 16'h5555, 1'b0, 1'b0, NO_RESULT},
        {1'b0, 4'd0, 16'haaaa, 1'b0, 1'b0, NO_RESULT},
        {1'b0, 4'd0, 16'h8000, 1'b1, 1'b0, NO_RESULT},
        // single frame in use
        {1'b1, 4'd1, 16'h0001, 1'b0, 1'b0, NO_RESULT},
        {1'b0, 4'd0, 16'h0001, 1'b0, 1'b0, NO_RESULT},
        {1'b0, 4'd0, 16'h7fff, 1'b0, 1'b0, NO_RESULT},
        // back to the full store, frames outside the count reappear
        {1'b1, 4'd8, 16'h7fff, 1'b0, 1'b0, NO_RESULT},
        {1'b0, 4'd0, 16'haaaa, 1'b1, 1'b0, NO_RESULT}
    };

    // counts for the first random phases, the rest are drawn
    localparam logic [FC_W-1:0] COUNT_SWEEP [5] = '{4'd1, 4'd15, 4'd0, 4'd8, 4'd2};

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    in_word_t           req       = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    out_word_t          rsp;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic [31:0]        prdata;
    logic               pready;

    lru_page_replacement u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // shadow copy of the frame store, the totals and the register
    logic [PAGE_BITS-1:0] shadow_page  [FRAMES] = '{default: '0};
    logic                 shadow_valid [FRAMES] = '{default: 1'b0};
    logic [AGE_W-1:0]     shadow_age   [FRAMES] = '{default: '0};
    logic [31:0]          shadow_hits   = '0;
    logic [31:0]          shadow_faults = '0;
    logic [FC_W-1:0]      shadow_count  = FC_RESET;

    // pending result words, oldest first
    out_word_t pending_results [$];

    int  mismatches    = 0;
    int  refs_sent     = 0;
    int  words_checked = 0;
    int  settings_done = 0;
    bit  quiet_phase   = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // zero acts as one, anything above the store acts as the full store
    function automatic int frames_in_use();
        if (shadow_count == '0)
            return 1;
        if (int'(shadow_count) > FRAMES)
            return FRAMES;
        return int'(shadow_count);
    endfunction

    // make frame f the most recent; only frames younger than limit grow older
    function automatic void promote_frame(int f, int limit, int n);
        for (int j = 0; j < n; j++)
        begin
            if (j != f && shadow_valid[j] && int'(shadow_age[j]) < limit &&
                int'(shadow_age[j]) < FRAMES - 1)
                shadow_age[j] = shadow_age[j] + 1'b1;
        end
        shadow_age[f] = '0;
    endfunction

    // one page reference through the shadow store
    function automatic out_word_t lru_lookup(in_word_t w);
        out_word_t r;
        int        n;
        int        slot;
        bit        found;
        bit        empty;
        r     = '0;
        n     = frames_in_use();
        slot  = 0;
        found = 1'b0;
        empty = 1'b0;
        // lowest matching frame wins
        for (int j = 0; j < n; j++)
        begin
            if (!found && shadow_valid[j] && shadow_page[j] == w.page)
            begin
                found = 1'b1;
                slot  = j;
            end
        end
        if (found)
        begin
            promote_frame(slot, int'(shadow_age[slot]), n);
            if (shadow_hits != '1)
                shadow_hits = shadow_hits + 1;
        end
        else
        begin
            for (int j = 0; j < n; j++)
            begin
                if (!empty && !shadow_valid[j])
                begin
                    empty = 1'b1;
                    slot  = j;
                end
            end
            if (empty)
                promote_frame(slot, FRAMES, n);
            else
            begin
                // oldest frame, ties go to the lowest index
                slot = 0;
                for (int j = 1; j < n; j++)
                begin
                    if (shadow_age[j] > shadow_age[slot])
                        slot = j;
                end
                r.evicted_valid = 1'b1;
                r.evicted_page  = shadow_page[slot];
                promote_frame(slot, int'(shadow_age[slot]), n);
            end
            shadow_page[slot]  = w.page;
            shadow_valid[slot] = 1'b1;
            if (shadow_faults != '1)
                shadow_faults = shadow_faults + 1;
        end
        r.hit         = found;
        r.frame_index = 3'(slot);
        r.hit_total   = shadow_hits;
        r.fault_total = shadow_faults;
        r.final_res   = w.last;
        return r;
    endfunction

    // offer one reference word after a random gap (none in a quiet phase); the prediction is made at accept
    task automatic send_ref(input in_word_t w, input bit typed, input out_word_t typed_res);
        int        gap;
        out_word_t predicted;
        gap = quiet_phase ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        do
            @(posedge clk);
        while (req_stall);
        predicted = lru_lookup(w);
        // typed rows keep the predictor in step but check the hand-written word
        pending_results.push_back(typed ? typed_res : predicted);
        refs_sent++;
    endtask

    // one apb transfer, setup then access, finishing at the edge with pready high
    task automatic apb_transfer(input bit wr, input logic [PADDR_W-1:0] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // register write only once the block is idle; a frame_count write is then read back
    task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        logic [31:0] rd;
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        apb_transfer(1'b1, addr, data, rd);
        if (addr == ADDR_FRAME_COUNT)
        begin
            shadow_count = data[FC_W-1:0];
            @(posedge clk);
            apb_transfer(1'b0, addr, '0, rd);
            if (rd !== 32'(shadow_count))
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: frame_count read back %0d, expected %0d",
                             rd, shadow_count);
            end
        end
        settings_done++;
    endtask

    // compare one accepted result word with the oldest prediction
    task automatic check_result(input out_word_t got);
        out_word_t exp;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch: result word %h with nothing pending", got);
        end
        else
        begin
            exp = pending_results.pop_front();
            if (got.hit !== exp.hit || got.frame_index !== exp.frame_index ||
                got.evicted_valid !== exp.evicted_valid ||
                got.evicted_page !== exp.evicted_page ||
                got.hit_total !== exp.hit_total || got.fault_total !== exp.fault_total ||
                got.final_res !== exp.final_res)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("mismatch at word %0d: hit %0d/%0d frame %0d/%0d evict %0d/%0d",
                             words_checked, got.hit, exp.hit,
                             got.frame_index, exp.frame_index,
                             got.evicted_valid, exp.evicted_valid);
                    $display("  page %h/%h hits %0d/%0d faults %0d/%0d final %0d/%0d",
                             got.evicted_page, exp.evicted_page,
                             got.hit_total, exp.hit_total,
                             got.fault_total, exp.fault_total,
                             got.final_res, exp.final_res);
                end
            end
        end
        words_checked++;
    endtask

    // result side: take a word, then hold stall for a random number of cycles, none in a quiet phase
    initial
    begin
        int hold_cycles;
        hold_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                check_result(rsp);
                hold_cycles = quiet_phase ? 0 : $urandom_range(0, MAX_GAP);
                if (hold_cycles > 0)
                    rsp_stall <= 1'b1;
            end
            else if (rsp_stall)
            begin
                if (hold_cycles > 1)
                    hold_cycles--;
                else
                begin
                    hold_cycles = 0;
                    rsp_stall <= 1'b0;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        in_word_t        w;
        logic [FC_W-1:0] cnt;
        logic [15:0]     pool [16];
        int              pool_n;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, the store starts empty at the reset count
        for (int i = 0; i < N_DIR; i++)
        begin
            if (DIR_ROWS[i].set_count)
                write_register(ADDR_FRAME_COUNT, 32'(DIR_ROWS[i].count));
            w.page = DIR_ROWS[i].page;
            w.last = DIR_ROWS[i].last;
            send_ref(w, DIR_ROWS[i].typed, DIR_ROWS[i].result);
        end

        // random phases, each with its own count and a small working set
        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            cnt = (phase < 5) ? COUNT_SWEEP[phase] : FC_W'($urandom_range(0, 15));
            // a write to an unused address must leave the count alone
            if (phase == 5)
                write_register(ADDR_SPARE, 32'($urandom_range(0, 15)));
            write_register(ADDR_FRAME_COUNT, 32'(cnt));
            quiet_phase = (phase % 4 == 1);
            // working set up to four pages larger than the frames in use forces evictions
            pool_n = frames_in_use() + $urandom_range(0, 4);
            for (int k = 0; k < pool_n; k++)
                pool[k] = 16'($urandom);
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                    w.page = 16'($urandom);
                else
                    w.page = pool[$urandom_range(0, pool_n - 1)];
                w.last = ($urandom_range(0, 15) == 0);
                send_ref(w, 1'b0, NO_RESULT);
            end
        end
        req_valid   <= 1'b0;
        quiet_phase = 1'b0;

        // drain, then a quiet tail to catch stray words
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d page references over %0d register settings, %0d words checked",
                 refs_sent, settings_done, words_checked);
        $display("summary: %0d hits and %0d faults predicted, %0d mismatches",
                 shadow_hits, shadow_faults, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
